// ===== hdl/base32_code_to_key_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Base32 code to key decoder: assertion macros
// Shared helpers for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef BASE32_CODE_TO_KEY_DECODER_DEFINES_SVH
`define BASE32_CODE_TO_KEY_DECODER_DEFINES_SVH

// A check that must hold in the same cycle as its condition.
`define B32D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A check that must hold in the cycle after its condition.
`define B32D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/b32d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 code to key decoder package
// Sizes, status codes, shared structures and the symbol lookup.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int KEY_BYTES   = 16;
    localparam int NUM_SYMBOLS = (KEY_BYTES * 8 + 4) / 5;
    localparam int IDX_W       = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int PTR_W       = $clog2(KEY_BYTES + 1);
    localparam int CNT_W       = $clog2(NUM_SYMBOLS + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 ** ADDR_W;
    localparam int STATUS_W    = 3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PADDING   = 3'd4;

    typedef struct packed {
        logic              ok;
        logic [4:0]        value;
    } b32d_sym_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } b32d_wr_t;

    typedef struct packed {
        logic                valid;
        logic                bank;
        logic [STATUS_W-1:0] status;
    } b32d_run_t;

    typedef struct packed {
        logic busy;
        logic held;
    } b32d_drain_stat_t;

    function automatic b32d_sym_t symbol_lookup(input logic [7:0] c);
        logic [7:0] u;
        b32d_sym_t  s;
        u = c;
        s.ok = 1'b1;
        s.value = 5'd0;
        if (c inside {[8'h61:8'h7A]})
        begin
            u = c - 8'h20;
        end
        case (u)
            8'h30, 8'h4F:          s.value = 5'd0;
            8'h31, 8'h49, 8'h4C:   s.value = 5'd1;
            8'h32:                 s.value = 5'd2;
            8'h33:                 s.value = 5'd3;
            8'h34:                 s.value = 5'd4;
            8'h35:                 s.value = 5'd5;
            8'h36:                 s.value = 5'd6;
            8'h37:                 s.value = 5'd7;
            8'h38:                 s.value = 5'd8;
            8'h39:                 s.value = 5'd9;
            8'h41:                 s.value = 5'd10;
            8'h42:                 s.value = 5'd11;
            8'h43:                 s.value = 5'd12;
            8'h44:                 s.value = 5'd13;
            8'h45:                 s.value = 5'd14;
            8'h46:                 s.value = 5'd15;
            8'h47:                 s.value = 5'd16;
            8'h48:                 s.value = 5'd17;
            8'h4A:                 s.value = 5'd18;
            8'h4B:                 s.value = 5'd19;
            8'h4D:                 s.value = 5'd20;
            8'h4E:                 s.value = 5'd21;
            8'h50:                 s.value = 5'd22;
            8'h51:                 s.value = 5'd23;
            8'h52:                 s.value = 5'd24;
            8'h53:                 s.value = 5'd25;
            8'h54:                 s.value = 5'd26;
            8'h56:                 s.value = 5'd27;
            8'h57:                 s.value = 5'd28;
            8'h58:                 s.value = 5'd29;
            8'h59:                 s.value = 5'd30;
            8'h5A:                 s.value = 5'd31;
            default:               s.ok = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/b32d_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 code to key decoder channels
// Valid/ready channels for typed characters and for decoded key bytes.
// ----------------------------------------------------------------------------
interface b32d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_code;

    modport source (output valid, output char_code, output end_of_code, input ready);
    modport sink   (input valid, input char_code, input end_of_code, output ready);
endinterface

interface b32d_key_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    key_byte;
    logic [3:0]                    byte_index;
    logic [b32d_pkg::STATUS_W-1:0] status;
    logic                          last_of_run;

    modport source (output valid, output key_byte, output byte_index, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input key_byte, input byte_index, input status,
                    input last_of_run, output ready);
endinterface

// ===== hdl/b32d_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 code to key decoder: symbol packer
// Decodes one character per cycle unless held, packs symbol bits into bytes and
// writes them to the fill bank of the key store, tracking the first error.
// ----------------------------------------------------------------------------
module b32d_packer (
    input  logic                      clk,
    input  logic                      rst_n,
    b32d_char_if.sink                 code,
    input  logic                      hold,
    output b32d_pkg::b32d_wr_t        wr,
    output b32d_pkg::b32d_run_t       run
);

    logic [11:0]                       acc_reg, acc_next;
    logic [3:0]                        pend_reg, pend_next;
    logic [b32d_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [b32d_pkg::PTR_W-1:0]        ptr_reg, ptr_next;
    logic [b32d_pkg::STATUS_W-1:0]     err_reg, err_next;
    logic                              bank_reg;

    logic                              accept;
    logic                              separator;
    b32d_pkg::b32d_sym_t               sym;
    logic [3:0]                        pend_sum;
    logic [3:0]                        shift;
    logic [11:0]                       pad_mask;
    logic [b32d_pkg::STATUS_W-1:0]     status;

    assign code.ready = !hold;
    assign accept     = code.valid && code.ready;
    assign separator  = code.char_code inside {8'h2D, 8'h20, 8'h09, 8'h0D, 8'h0A};
    assign sym        = b32d_pkg::symbol_lookup(code.char_code);
    assign pend_sum   = pend_reg + 4'd5;
    assign shift      = pend_sum - 4'd8;

    always_comb
    begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        err_next   = err_reg;
        wr.en      = 1'b0;
        wr.addr    = {bank_reg, ptr_reg[b32d_pkg::IDX_W-1:0]};
        wr.data    = 8'd0;
        if (accept && err_reg == b32d_pkg::ST_OK && !separator)
        begin
            if (!sym.ok)
            begin
                err_next = b32d_pkg::ST_BAD_CHAR;
            end
            else if (count_reg >= b32d_pkg::CNT_W'(b32d_pkg::NUM_SYMBOLS))
            begin
                err_next = b32d_pkg::ST_TOO_LONG;
            end
            else
            begin
                count_next = count_reg + b32d_pkg::CNT_W'(1);
                acc_next   = {acc_reg[6:0], sym.value};
                if (pend_sum >= 4'd8)
                begin
                    wr.en     = ptr_reg < b32d_pkg::PTR_W'(b32d_pkg::KEY_BYTES);
                    wr.data   = 8'(acc_next >> shift);
                    ptr_next  = ptr_reg + b32d_pkg::PTR_W'(1);
                    pend_next = shift;
                end
                else
                begin
                    pend_next = pend_sum;
                end
            end
        end
    end

    always_comb
    begin
        pad_mask = (12'd1 << pend_next) - 12'd1;
        status   = err_next;
        if (status == b32d_pkg::ST_OK
            && count_next != b32d_pkg::CNT_W'(b32d_pkg::NUM_SYMBOLS))
        begin
            status = b32d_pkg::ST_TOO_SHORT;
        end
        if (status == b32d_pkg::ST_OK && (acc_next & pad_mask) != 12'd0)
        begin
            status = b32d_pkg::ST_PADDING;
        end
        run.valid  = accept && code.end_of_code;
        run.bank   = bank_reg;
        run.status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            err_reg   <= b32d_pkg::ST_OK;
            bank_reg  <= 1'b0;
        end
        else if (accept && code.end_of_code)
        begin
            acc_reg   <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            err_reg   <= b32d_pkg::ST_OK;
            bank_reg  <= !bank_reg;
        end
        else
        begin
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== hdl/b32d_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 code to key decoder: key store and drain
// Two-bank key store; a finished code is read out one byte per cycle into the
// output register, unless the key output stalls, while the next code fills the other bank.
// ----------------------------------------------------------------------------
module b32d_drain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  b32d_pkg::b32d_wr_t           wr,
    input  b32d_pkg::b32d_run_t          run,
    b32d_key_if.source                   key,
    output b32d_pkg::b32d_drain_stat_t   stat
);

    logic [7:0]                    mem [b32d_pkg::MEM_DEPTH];

    logic                          active_reg;
    logic [b32d_pkg::IDX_W-1:0]    idx_reg;
    logic                          bank_reg;
    logic [b32d_pkg::STATUS_W-1:0] status_reg;
    logic                          pvalid_reg;
    logic                          pbank_reg;
    logic [b32d_pkg::STATUS_W-1:0] pstatus_reg;

    logic                          out_valid_reg;
    logic [7:0]                    data_reg;
    logic [b32d_pkg::IDX_W-1:0]    out_idx_reg;
    logic [b32d_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_last_reg;

    logic                          advance;
    logic                          load;
    logic                          done;
    logic                          busy_after;

    assign advance    = !out_valid_reg || key.ready;
    assign load       = active_reg && advance;
    assign done       = load && idx_reg == b32d_pkg::IDX_W'(b32d_pkg::KEY_BYTES - 1);
    assign busy_after = active_reg && !done;

    assign key.valid       = out_valid_reg;
    assign key.key_byte    = (out_status_reg == b32d_pkg::ST_OK) ? data_reg : 8'd0;
    assign key.byte_index  = 4'(out_idx_reg);
    assign key.status      = out_status_reg;
    assign key.last_of_run = out_last_reg;

    assign stat.busy = active_reg;
    assign stat.held = pvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (load)
        begin
            data_reg       <= mem[{bank_reg, idx_reg}];
            out_idx_reg    <= idx_reg;
            out_status_reg <= status_reg;
            out_last_reg   <= idx_reg == b32d_pkg::IDX_W'(b32d_pkg::KEY_BYTES - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            bank_reg      <= 1'b0;
            status_reg    <= b32d_pkg::ST_OK;
            pvalid_reg    <= 1'b0;
            pbank_reg     <= 1'b0;
            pstatus_reg   <= b32d_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= active_reg;
            end
            if (load)
            begin
                idx_reg <= done ? '0 : idx_reg + b32d_pkg::IDX_W'(1);
            end
            if (pvalid_reg)
            begin
                if (done)
                begin
                    bank_reg   <= pbank_reg;
                    status_reg <= pstatus_reg;
                    pvalid_reg <= 1'b0;
                end
            end
            else if (run.valid)
            begin
                if (busy_after)
                begin
                    pvalid_reg  <= 1'b1;
                    pbank_reg   <= run.bank;
                    pstatus_reg <= run.status;
                end
                else
                begin
                    active_reg <= 1'b1;
                    bank_reg   <= run.bank;
                    status_reg <= run.status;
                end
            end
            else if (done)
            begin
                active_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/base32_code_to_key_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 code to key decoder
// Turns a typed Crockford base32 pairing code into a sixteen-byte key.
// ----------------------------------------------------------------------------
// Characters are taken one item per clock. Separators are skipped, case is
// folded and O, I and L are read as 0, 1 and 1. The item that ends a code
// produces sixteen key items, one per cycle from the key store while the key
// output is not stalled, each with the status of the code; the bytes are zero
// unless the status is ok. The key store has two banks, so the next code is
// taken while the previous one is read out. Input is held off only when a
// second finished code waits behind a read-out still running. With the key
// output never stalled, only a code shorter than sixteen characters meets
// this; a stalled key output lengthens the read-out, and so the wait.
// ----------------------------------------------------------------------------
`include "base32_code_to_key_decoder_defines.svh"

module base32_code_to_key_decoder (
    input  logic        clk,
    input  logic        rst_n,
    b32d_char_if.sink   code,
    b32d_key_if.source  key
);

    b32d_pkg::b32d_wr_t          wr;
    b32d_pkg::b32d_run_t         run;
    b32d_pkg::b32d_drain_stat_t  drain_stat;

    b32d_packer u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .code  (code),
        .hold  (drain_stat.held),
        .wr    (wr),
        .run   (run)
    );

    b32d_drain u_drain (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .run   (run),
        .key   (key),
        .stat  (drain_stat)
    );

    `B32D_ASSERT_NOW(a_held_needs_drain, !code.ready, drain_stat.busy, "Input held with no read-out in progress.")
    `B32D_ASSERT_NOW(a_error_zeroes_key, key.valid && key.status != b32d_pkg::ST_OK, key.key_byte == 8'd0, "Key byte not zero on a failed code.")
    `B32D_ASSERT_NEXT(a_index_steps, key.valid && key.ready && !key.last_of_run, key.valid && key.byte_index == 4'($past(key.byte_index) + 4'd1), "Key items not in consecutive order.")

endmodule
